>>> sv/p2i_pkg.sv
// Package for the 2x2 pooling stream core: register indexes, mode codes,
// shared structs and the pair combine function. No dependencies.
`default_nettype none

package p2i_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_POOL_MODE     = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

    // pool modes; bit 1 set means average
    localparam logic [1:0] MODE_MAX = 2'd0;
    localparam logic [1:0] MODE_MIN = 2'd1;

    // clamped dimensions fit 14 bits for any supported maximum (up to 8192)
    localparam int DIM_W = 14;
    localparam int NCH_W = 3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [NCH_W-1:0] nch;
    } cfg_t;

    // item waiting for its line store read
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [8:0] pair;
    } s1_t;

    function automatic logic [9:0] combine(input logic [1:0] mode,
                                           input logic [8:0] a,
                                           input logic [8:0] b);
        logic [9:0] r;
        if (mode[1]) begin
            r = {1'b0, a} + {1'b0, b};
        end else if (mode == MODE_MIN) begin
            r = (a < b) ? {1'b0, a} : {1'b0, b};
        end else begin
            r = (a > b) ? {1'b0, a} : {1'b0, b};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/p2i_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module p2i_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/p2i_cfg.sv
// Configuration registers of the pooling core, with clamping of the
// dimensions to the supported range. Depends on p2i_pkg.
`default_nettype none

module p2i_cfg #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [11:0]   cfg_data,
    output p2i_pkg::cfg_t      cfg
);

    localparam int DW = p2i_pkg::DIM_W;
    localparam int NW = p2i_pkg::NCH_W;

    logic [1:0]  mode_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [2:0]  nch_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= p2i_pkg::MODE_MAX;
            width_reg  <= 12'd2048;
            height_reg <= 12'd2048;
            nch_reg    <= 3'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                p2i_pkg::REG_POOL_MODE:     mode_reg   <= cfg_data[1:0];
                p2i_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                p2i_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                p2i_pkg::REG_CHANNEL_COUNT: nch_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.mode = mode_reg;

        if (width_reg == 12'd0) begin
            cfg.width = DW'(1);
        end else if ({{(DW-12){1'b0}}, width_reg} > DW'(MAX_WIDTH)) begin
            cfg.width = DW'(MAX_WIDTH);
        end else begin
            cfg.width = {{(DW-12){1'b0}}, width_reg};
        end

        if (height_reg == 12'd0) begin
            cfg.height = DW'(1);
        end else if ({{(DW-12){1'b0}}, height_reg} > DW'(MAX_HEIGHT)) begin
            cfg.height = DW'(MAX_HEIGHT);
        end else begin
            cfg.height = {{(DW-12){1'b0}}, height_reg};
        end

        if (nch_reg == 3'd0) begin
            cfg.nch = NW'(1);
        end else if (nch_reg > NW'(MAX_CHANNELS)) begin
            cfg.nch = NW'(MAX_CHANNELS);
        end else begin
            cfg.nch = nch_reg;
        end
    end

endmodule

`default_nettype wire

>>> sv/p2i_front.sv
// Input side of the pooling core: raster counters, left-sample hold,
// horizontal pair combine and line store access. Depends on p2i_pkg.
`default_nettype none

module p2i_front #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire p2i_pkg::cfg_t   cfg,
    input  wire logic            s_valid,
    input  wire logic            s_ready,
    input  wire logic [7:0]      s_sample,
    input  wire logic            s_start_of_frame,
    output logic                 mem_we,
    output logic                 mem_re,
    output logic [((MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1)
                  + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1) - 1:0] mem_addr,
    output logic [8:0]           mem_wdata,
    output p2i_pkg::s1_t         s1
);

    localparam int DW     = p2i_pkg::DIM_W;
    localparam int NW     = p2i_pkg::NCH_W;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PAIR_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1;

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [CH_W-1:0]  ch_reg, ch_next, ch_cur;
    logic [7:0]       left_hold_reg [2**CH_W];

    logic             accept;
    logic [NW-1:0]    ch_inc;
    logic [DW-1:0]    col_inc;
    logic [DW-1:0]    row_inc;
    logic [PAIR_W-1:0] pair_idx;
    logic [9:0]       pair_full;
    logic [8:0]       pair;
    logic             last;

    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic [8:0]       s1_pair_reg;

    assign accept = s_valid & s_ready;

    // frame start clears the counters before this item uses them
    assign col_cur = s_start_of_frame ? '0 : col_reg;
    assign row_cur = s_start_of_frame ? '0 : row_reg;
    assign ch_cur  = s_start_of_frame ? '0 : ch_reg;

    assign ch_inc  = NW'(ch_cur) + NW'(1);
    assign col_inc = DW'(col_cur) + DW'(1);
    assign row_inc = DW'(row_cur) + DW'(1);

    always_comb begin
        ch_next  = ch_cur + CH_W'(1);
        col_next = col_cur;
        row_next = row_cur;
        if (ch_inc >= cfg.nch) begin
            ch_next = '0;
            if (col_inc >= cfg.width) begin
                col_next = '0;
                row_next = (row_inc >= cfg.height) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    assign pair_full = p2i_pkg::combine(cfg.mode, {1'b0, left_hold_reg[ch_cur]},
                                        {1'b0, s_sample});
    assign pair      = pair_full[8:0];

    assign last = (col_inc == {cfg.width[DW-1:1], 1'b0})
               && (row_inc == {cfg.height[DW-1:1], 1'b0})
               && (ch_inc == cfg.nch);

    assign pair_idx  = PAIR_W'(col_cur >> 1);
    assign mem_addr  = {pair_idx, ch_cur};
    assign mem_wdata = pair;
    assign mem_we    = accept & col_cur[0] & ~row_cur[0];
    assign mem_re    = accept & col_cur[0] & row_cur[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            ch_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                ch_reg  <= ch_next;
            end
            // s_ready high means stage 1 is empty or moving on this edge
            if (s_ready) begin
                s1_valid_reg <= mem_re;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !col_cur[0]) begin
            left_hold_reg[ch_cur] <= s_sample;
        end
        if (mem_re) begin
            s1_pair_reg <= pair;
            s1_last_reg <= last;
        end
    end

    assign s1 = '{valid: s1_valid_reg, last: s1_last_reg, pair: s1_pair_reg};

endmodule

`default_nettype wire

>>> sv/pooling_2x2_image_stream_core.sv
// 2x2 max/min/average pooling of an interleaved raster sample stream.
// Depends on p2i_pkg, p2i_cfg, p2i_front and p2i_ram.
//
// Usage:
//   s_ channel carries one 8-bit channel sample per item, pixels in raster
//   order with channels interleaved; s_start_of_frame marks a frame's first
//   sample and restarts the counters. m_ channel gives one pooled value per
//   channel for each 2x2 window, on the item that carries the window's
//   bottom-right sample; m_last_of_frame flags the frame's final value.
//   An odd last column or row is dropped.
//   cfg_ channel writes pool_mode, image_width, image_height, channel_count
//   (index 0..3); write only while the core is idle.
// Timing:
//   One item per cycle sustained while m_ is ready. A result passes the line
//   store read, held with its pair in stage 1, then the final combine goes to
//   the output register.
//   A stalled m_ side holds the output register; items may enter until one
//   that reads the store waits in stage 1; then s_ready drops until m_ drains.
// Reset: counters and valid flags clear; registers take their default values.
//   The line store has no reset; a frame start before the first frame keeps
//   every read behind its write.
`default_nettype none

module pooling_2x2_image_stream_core #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_sample,
    input  wire logic        s_start_of_frame,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_pooled_value,
    output logic             m_last_of_frame
);

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PAIR_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1;
    localparam int ADDR_W = PAIR_W + CH_W;

    p2i_pkg::cfg_t     cfg;
    p2i_pkg::s1_t      s1;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [8:0]        mem_wdata;
    logic [8:0]        mem_rdata;

    logic              out_free;
    logic [9:0]        quad;
    logic [9:0]        scaled;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        pooled_reg, pooled_next;
    logic              last_reg;

    p2i_cfg #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    p2i_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_start_of_frame(s_start_of_frame),
        .mem_we          (mem_we),
        .mem_re          (mem_re),
        .mem_addr        (mem_addr),
        .mem_wdata       (mem_wdata),
        .s1              (s1)
    );

    p2i_ram #(
        .WIDTH(9),
        .DEPTH(2**ADDR_W)
    ) u_line (
        .aclk (aclk),
        .we   (mem_we),
        .re   (mem_re),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1.valid || out_free;

    // vertical combine of the stored even-row partial with this row's pair
    assign quad   = p2i_pkg::combine(cfg.mode, mem_rdata, s1.pair);
    assign scaled = cfg.mode[1] ? (quad >> 2) : quad;

    always_comb begin
        pooled_next  = (scaled > 10'd255) ? 8'd255 : scaled[7:0];
        m_valid_next = out_free ? s1.valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1.valid) begin
            pooled_reg <= pooled_next;
            last_reg   <= s1.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pooled_value  = pooled_reg;
    assign m_last_of_frame = last_reg;

endmodule

`default_nettype wire
